// ===== sv/csm_pkg.sv =====
// Shared types and constants for the compose sequence matcher.
package csm_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned SYM_W  = 29;

  typedef enum logic [FUNC_W-1:0] {
    FN_PRESS  = 2'd0,
    FN_APPEND = 2'd1,
    FN_COMMIT = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PASS     = 3'd0,
    ST_COMPOSED = 3'd1,
    ST_PARTIAL  = 3'd2,
    ST_INVALID  = 3'd3,
    ST_ACCEPTED = 3'd4,
    ST_REJECTED = 3'd5
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SYM_W-1:0]  symbol_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;      // latch the incoming item and prepare the typed buffer
    logic scan_rd;   // issue a table read at the scan pointer
    logic scan_adv;  // advance the scan pointer
    logic eval;      // evaluate the registered read data
    logic write;     // write the pending definition to the table
    logic finish;    // form the result and update buffers
  } csm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last; // scan pointer has reached the entry count
    logic need_scan; // item needs a table scan
    logic do_write;  // commit outcome is an accepted write
  } csm_stat_t;

endpackage

// ===== sv/compose_sequence_matcher_unit.sv =====
// Top level of the compose sequence matcher.
//
//  Channel | Direction | Payload     | Handshake
//  in      | input     | in_item_t   | in_valid / in_stall
//  out     | output    | out_item_t  | out_valid / out_stall
//
// Every item takes one transfer in; a key press or commit then sweeps the stored
// definitions, one table row per cycle, reading the table memory at the scan
// pointer, while append and clear skip the sweep.
// Reset clears the entry count and both buffer lengths; table contents are
// kept undefined and are only read below the entry count.
// A result waits in an output register while out_stall is high; the next
// transfer in may be taken meanwhile, but its result is held back until the
// waiting one has moved on.
module compose_sequence_matcher_unit #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_SEQ       = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csm_pkg::out_item_t  out_data
);
  import csm_pkg::*;

  csm_cmd_t  cmd;
  csm_stat_t stat;

  // The controller owns the handshakes; the datapath owns all data storage.
  csm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  csm_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SEQ       (MAX_SEQ)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !in_stall) else $error("item taken while stalled");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && out_stall)) else $error("result overwritten");
  a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> stat.do_write) else $error("write without accepted commit");
`endif
endmodule

// ===== sv/csm_ctrl.sv =====
// Controller state machine sequencing table scans and result handoff.
module csm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  csm_pkg::csm_stat_t  stat,
  output csm_pkg::csm_cmd_t   cmd
);
  import csm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.need_scan || stat.scan_last) begin
          state_nxt = S_WAIT;
        end else begin
          cmd.scan_rd  = 1'b1;
          cmd.scan_adv = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        // Read data of the previous address is now registered.
        cmd.eval = 1'b1;
        if (stat.need_scan && !stat.scan_last) begin
          cmd.scan_rd  = 1'b1;
          cmd.scan_adv = 1'b1;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.eval = 1'b1;
        if (stat.do_write) begin
          cmd.write = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> !cmd.write) else $error("double table write");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("result not presented");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == S_SCAN) else $error("take outside idle");
`endif
endmodule

// ===== sv/csm_dp.sv =====
// Datapath: definition table, typed and pending buffers, match logic.
module csm_dp #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_SEQ       = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  csm_pkg::in_item_t   in_data,
  input  csm_pkg::csm_cmd_t   cmd,
  output csm_pkg::csm_stat_t  stat,
  output csm_pkg::out_item_t  out_data
);
  import csm_pkg::*;

  localparam int unsigned SYM_BITS = SYM_W;
  localparam int unsigned EW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LW = $clog2(MAX_SEQ + 1);
  localparam int unsigned PW = $clog2(MAX_SEQ);
  localparam int unsigned RW = MAX_SEQ * SYM_BITS;

  // One table row holds a whole sequence, its length and its result.
  logic [RW-1:0]       mem_seq [TABLE_ENTRIES];
  logic [LW-1:0]       mem_len [TABLE_ENTRIES];
  logic [SYM_BITS-1:0] mem_prod[TABLE_ENTRIES];

  logic [RW-1:0]       rd_seq_r;
  logic [LW-1:0]       rd_len_r;
  logic [SYM_BITS-1:0] rd_prod_r;
  logic                rd_vld_r, rd_vld_nxt;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       ptr_r;
  logic [FUNC_W-1:0]   func_r;
  logic [SYM_BITS-1:0] sym_r;

  logic [SYM_BITS-1:0] typed_r  [MAX_SEQ];
  logic [LW-1:0]       tlen_r;
  logic [SYM_BITS-1:0] pend_r   [MAX_SEQ];
  logic [LW-1:0]       plen_r;
  logic                povf_r;

  logic                exact_r, prefix_r, dup_r;
  logic                wrote_r;
  logic [SYM_BITS-1:0] prod_r;
  out_item_t           out_r;

  logic [LW-1:0]       tlen_eff;
  logic [EW-1:0]       waddr;
  logic [RW-1:0]       pend_row;
  logic                row_match_t, row_match_p;

  assign waddr = count_r[EW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_SEQ; i++) begin
      pend_row[i*SYM_BITS +: SYM_BITS] = pend_r[i];
    end
  end

  // Effective typed length: the new key is already in the buffer.
  assign tlen_eff = tlen_r;

  always_comb begin
    row_match_t = 1'b1;
    row_match_p = (rd_len_r == plen_r);
    for (int i = 0; i < MAX_SEQ; i++) begin
      if (LW'(i) < tlen_eff && rd_seq_r[i*SYM_BITS +: SYM_BITS] != typed_r[i]) begin
        row_match_t = 1'b0;
      end
      if (LW'(i) < plen_r && rd_seq_r[i*SYM_BITS +: SYM_BITS] != pend_r[i]) begin
        row_match_p = 1'b0;
      end
    end
  end

  assign stat.scan_last = (ptr_r == count_r);
  assign stat.need_scan = (func_r == FN_PRESS) || (func_r == FN_COMMIT);
  assign stat.do_write  = (func_r == FN_COMMIT) && plen_r != '0 && !povf_r
                          && count_r != CW'(TABLE_ENTRIES) && !dup_r;

  // Table memory.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem_seq[waddr]  <= pend_row;
      mem_len[waddr]  <= plen_r;
      mem_prod[waddr] <= sym_r;
    end
    if (cmd.scan_rd) begin
      rd_seq_r  <= mem_seq[ptr_r[EW-1:0]];
      rd_len_r  <= mem_len[ptr_r[EW-1:0]];
      rd_prod_r <= mem_prod[ptr_r[EW-1:0]];
    end
  end

  assign rd_vld_nxt = cmd.scan_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      count_r  <= '0;
      ptr_r    <= '0;
      func_r   <= FN_APPEND;
      tlen_r   <= '0;
      plen_r   <= '0;
      povf_r   <= 1'b0;
      exact_r  <= 1'b0;
      prefix_r <= 1'b0;
      dup_r    <= 1'b0;
      wrote_r  <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
      if (cmd.take) begin
        func_r   <= in_data.func;
        sym_r    <= in_data.symbol_value[SYM_BITS-1:0];
        ptr_r    <= '0;
        exact_r  <= 1'b0;
        prefix_r <= 1'b0;
        dup_r    <= 1'b0;
        wrote_r  <= 1'b0;
        if (in_data.func == FN_PRESS) begin
          if (tlen_r >= LW'(MAX_SEQ)) begin
            typed_r[0] <= in_data.symbol_value[SYM_BITS-1:0];
            tlen_r     <= LW'(1);
          end else begin
            typed_r[tlen_r[PW-1:0]] <= in_data.symbol_value[SYM_BITS-1:0];
            tlen_r <= tlen_r + LW'(1);
          end
        end
      end
      if (cmd.scan_adv) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.eval && rd_vld_r) begin
        if (rd_len_r >= tlen_r && rd_len_r <= LW'(MAX_SEQ) && row_match_t) begin
          if (rd_len_r == tlen_r) begin
            if (!exact_r) begin
              exact_r <= 1'b1;
              prod_r  <= rd_prod_r;
            end
          end else begin
            prefix_r <= 1'b1;
          end
        end
        if (row_match_p) begin
          dup_r <= 1'b1;
        end
      end
      if (cmd.write) begin
        count_r <= count_r + CW'(1);
        wrote_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_r.symbol_out <= '0;
        out_r.status     <= ST_ACCEPTED;
        unique case (func_r)
          FN_PRESS: begin
            if (exact_r) begin
              tlen_r           <= '0;
              out_r.status     <= ST_COMPOSED;
              out_r.symbol_out <= SYM_W'(prod_r);
            end else if (prefix_r) begin
              out_r.status <= ST_PARTIAL;
            end else if (tlen_r == LW'(1)) begin
              tlen_r           <= '0;
              out_r.status     <= ST_PASS;
              out_r.symbol_out <= SYM_W'(sym_r);
            end else begin
              tlen_r       <= '0;
              out_r.status <= ST_INVALID;
            end
          end
          FN_APPEND: begin
            if (plen_r >= LW'(MAX_SEQ)) begin
              povf_r       <= 1'b1;
              out_r.status <= ST_REJECTED;
            end else begin
              pend_r[plen_r[PW-1:0]] <= sym_r;
              plen_r <= plen_r + LW'(1);
            end
          end
          FN_COMMIT: begin
            // The entry count has already moved on after a write, so the
            // outcome is taken from the write itself.
            if (!wrote_r) begin
              out_r.status <= ST_REJECTED;
            end
            plen_r <= '0;
            povf_r <= 1'b0;
          end
          FN_CLEAR: begin
            count_r <= '0;
            tlen_r  <= '0;
            plen_r  <= '0;
            povf_r  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= count_r) else $error("scan pointer past table");
  a_tlen_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> tlen_r <= LW'(MAX_SEQ)) else $error("typed length overflow");
`endif
endmodule

// ===== tb/compose_sequence_matcher_unit_checker.sv =====
// Checker for the compose sequence matcher: predicts each result and compares it.
`timescale 1ns / 100ps
module compose_sequence_matcher_unit_checker #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned MAX_SEQ       = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  csm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  csm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 results_owed
);
  import csm_pkg::*;

  logic [SYM_W-1:0] tbl_sym [TABLE_ENTRIES][MAX_SEQ];
  int unsigned      tbl_len [TABLE_ENTRIES];
  logic [SYM_W-1:0] tbl_prod [TABLE_ENTRIES];
  int unsigned      n_entries;
  logic [SYM_W-1:0] typed [MAX_SEQ];
  int unsigned      typed_len;
  logic [SYM_W-1:0] pend [MAX_SEQ];
  int unsigned      pend_len;
  bit               pend_ovf;
  out_item_t        awaited_results[$];

  function automatic out_item_t compose_outcome(in_item_t it);
    out_item_t r;
    bit exact, prefix, same;
    r.status = ST_ACCEPTED;
    r.symbol_out = '0;
    case (func_t'(it.func))
      FN_PRESS: begin
        exact = 0;
        prefix = 0;
        if (typed_len >= MAX_SEQ) typed_len = 0;
        typed[typed_len] = it.symbol_value;
        typed_len++;
        for (int e = 0; e < n_entries; e++) begin
          if (tbl_len[e] < typed_len) continue;
          same = 1;
          for (int i = 0; i < typed_len; i++)
            if (tbl_sym[e][i] != typed[i]) same = 0;
          if (!same) continue;
          if (tbl_len[e] == typed_len) begin
            if (!exact) begin
              exact = 1;
              r.symbol_out = tbl_prod[e];
            end
          end else prefix = 1;
        end
        if (exact) begin
          typed_len = 0;
          r.status = ST_COMPOSED;
        end else if (prefix) begin
          r.status = ST_PARTIAL;
        end else if (typed_len == 1) begin
          typed_len = 0;
          r.status = ST_PASS;
          r.symbol_out = it.symbol_value;
        end else begin
          typed_len = 0;
          r.status = ST_INVALID;
        end
      end
      FN_APPEND: begin
        if (pend_len >= MAX_SEQ) begin
          pend_ovf = 1;
          r.status = ST_REJECTED;
        end else begin
          pend[pend_len] = it.symbol_value;
          pend_len++;
        end
      end
      FN_COMMIT: begin
        same = 0;
        for (int e = 0; e < n_entries && !same; e++) begin
          if (tbl_len[e] == pend_len) begin
            same = 1;
            for (int i = 0; i < pend_len; i++)
              if (tbl_sym[e][i] != pend[i]) same = 0;
          end
        end
        if (pend_len == 0 || pend_ovf || n_entries >= TABLE_ENTRIES || same) begin
          r.status = ST_REJECTED;
        end else begin
          for (int i = 0; i < pend_len; i++) tbl_sym[n_entries][i] = pend[i];
          tbl_len[n_entries] = pend_len;
          tbl_prod[n_entries] = it.symbol_value;
          n_entries++;
        end
        pend_len = 0;
        pend_ovf = 0;
      end
      default: begin
        n_entries = 0;
        typed_len = 0;
        pend_len = 0;
        pend_ovf = 0;
      end
    endcase
    return r;
  endfunction

  assign results_owed = awaited_results.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      n_entries = 0;
      typed_len = 0;
      pend_len = 0;
      pend_ovf = 0;
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d symbol %h",
                     out_data.status, out_data.symbol_out);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status || out_data.symbol_out !== want.symbol_out) begin
            if (fail_count < 10)
              $display("result differs: expected status %0d symbol %h, got status %0d symbol %h",
                       want.status, want.symbol_out, out_data.status, out_data.symbol_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(compose_outcome(in_data));
    end
  end

endmodule

// ===== tb/compose_sequence_matcher_unit_test.sv =====
// Testbench top for the compose sequence matcher: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module compose_sequence_matcher_unit_test;
  import csm_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned MAX_SEQ       = 8;
  // A key press may sweep the whole table, and the receiver may stall.
  localparam int unsigned IDLE_LIMIT    = 4000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        results_owed;
  int        quiet_cycles = 0;

  // Sequences loaded as definitions, kept so that presses can replay them.
  logic [SYM_W-1:0] known_seq [$][$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  compose_sequence_matcher_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_SEQ(MAX_SEQ)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  compose_sequence_matcher_unit_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_SEQ(MAX_SEQ)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // The receiver draws a fresh stall length after every transfer out; during some
  // stretches it never stalls at all.
  always @(posedge clk) begin
    static int stall_left = 0;
    static int calm = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (calm > 0) calm--;
        else if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 60);
        stall_left = (calm > 0) ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("compose_sequence_matcher_unit: mismatch");
      $finish;
    end
  end

  // Sends one transfer, after a random gap unless no_gap is set, holding the payload until it is taken.
  // Valid stays high after the transfer; the next call or the caller drops it.
  task automatic send_item(input func_t fn, input logic [SYM_W-1:0] sym, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.func <= fn;
    in_data.symbol_value <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] rand_sym();
    // Mostly a small alphabet, so that sequences collide and share prefixes.
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? '1 : '0;
      1: return SYM_W'($urandom());
      default: return SYM_W'($urandom_range(0, 5));
    endcase
  endfunction

  // Loads one definition of the given length and commits it.
  task automatic define_seq(input int len, input logic [SYM_W-1:0] produced);
    logic [SYM_W-1:0] seq [$];
    seq = {};
    for (int i = 0; i < len; i++) begin
      seq.push_back(rand_sym());
      send_item(FN_APPEND, seq[i]);
    end
    send_item(FN_COMMIT, produced);
    if (len > 0 && len <= MAX_SEQ) known_seq.push_back(seq);
  endtask

  // Types a stored sequence, whole or cut short, or with an extra random key at the end.
  task automatic type_seq(output int count);
    int idx, n;
    idx = $urandom_range(0, known_seq.size() - 1);
    n = known_seq[idx].size();
    case ($urandom_range(0, 5))
      0: n = $urandom_range(1, n);
      1: n = n + 1;
      default: ;
    endcase
    for (int i = 0; i < n; i++)
      send_item(FN_PRESS, (i < known_seq[idx].size()) ? known_seq[idx][i] : rand_sym());
    count = n;
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, extremes, overflow, duplicates and exact-versus-longer.
    send_item(FN_PRESS, '1);
    send_item(FN_PRESS, '0);
    send_item(FN_COMMIT, '1);
    for (int i = 0; i <= MAX_SEQ; i++) send_item(FN_APPEND, SYM_W'(i));
    send_item(FN_COMMIT, SYM_W'('h55));
    send_item(FN_APPEND, '0);
    send_item(FN_COMMIT, '1);
    send_item(FN_APPEND, '0);
    send_item(FN_COMMIT, SYM_W'('h123));
    send_item(FN_APPEND, '0);
    send_item(FN_APPEND, '1);
    send_item(FN_COMMIT, SYM_W'('h77));
    send_item(FN_PRESS, '0);
    send_item(FN_PRESS, '1);
    send_item(FN_CLEAR, '1);
    send_item(FN_PRESS, '0);

    // Random part in rounds: most rounds define and type sequences, a few add noise.
    sent = 0;
    while (sent < 1300) begin
      int pick;
      int n_typed;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_item(FN_CLEAR, rand_sym());
        known_seq = {};
        sent++;
      end else if (pick < 3) begin
        // Fill the table to its end with short definitions, back to back.
        for (int i = 0; i < TABLE_ENTRIES + 2; i++) begin
          send_item(FN_APPEND, SYM_W'(i) ^ SYM_W'('h1AB0000), 1);
          send_item(FN_COMMIT, SYM_W'(i), 1);
        end
        send_item(FN_PRESS, SYM_W'('h1AB0000) ^ SYM_W'(TABLE_ENTRIES - 1));
        sent += 2 * TABLE_ENTRIES + 5;
      end else if (pick < 5) begin
        // Hold the sender back until every outstanding result has come.
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        send_item(FN_PRESS, rand_sym());
        sent++;
      end else if (pick < 30 || known_seq.size() == 0) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_SEQ + 1)
                                           : $urandom_range(1, 3);
        define_seq(len, rand_sym());
        sent += len + 1;
      end else if (pick < 85) begin
        type_seq(n_typed);
        sent += n_typed;
      end else begin
        send_item(func_t'($urandom_range(0, 2)), rand_sym());
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 20) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("compose_sequence_matcher_unit: match");
    end else begin
      $display("compose_sequence_matcher_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/csm_pkg.sv
sv/csm_ctrl.sv
sv/csm_dp.sv
sv/compose_sequence_matcher_unit.sv
tb/compose_sequence_matcher_unit_checker.sv
tb/compose_sequence_matcher_unit_test.sv
